FILE: design/hvd_pkg.sv
// hvd_pkg: shared types, constants and elaboration-time table builders
// for the haversine distance pipeline. No dependencies.
package hvd_pkg;

    typedef logic signed [63:0] word_t;

    localparam int    FRAC       = 60;
    localparam word_t ONE        = word_t'(64'd1 << FRAC);
    localparam logic [63:0] HALF_UNITS = 64'd3600000000;
    localparam word_t TWO_R_CM   = word_t'(64'd1274200000);
    localparam word_t MAX_CM     = word_t'(64'd2001508680);
    localparam int    MUL_LAT    = 4;
    localparam int    SQRT_STEPS = 64;

    // restoring long division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // (a * b) >> s rounded to nearest, ties away from zero
    function automatic word_t mul_shift_c(input word_t a, input word_t b, input int s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] pr;
        logic [63:0]  q;
        neg = a[63] ^ b[63];
        ua  = a[63] ? 64'(-a) : 64'(a);
        ub  = b[63] ? 64'(-b) : 64'(b);
        pr  = {64'd0, ua} * {64'd0, ub};
        pr  = pr + (128'd1 << (s - 1));
        q   = 64'(pr >> s) & 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? word_t'(-q) : word_t'(q);
    endfunction

    function automatic logic [63:0] atan_inv(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] nn;
        logic [63:0] sum;
        logic [63:0] term;
        p   = udiv64(64'(ONE), n);
        nn  = n * n;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 0) begin
                term = udiv64(p, 64'(2 * k + 1));
                sum  = k[0] ? sum - term : sum + term;
                p    = udiv64(p, nn);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] quarter_pi();
        return 4 * atan_inv(64'd5) - atan_inv(64'd239);
    endfunction

    // arctangent of 2^-i in Q60 radians
    function automatic word_t atn_entry(input int i);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        p   = 64'(ONE) >> i;
        sum = '0;
        if (i == 0) begin
            sum = quarter_pi();
        end else begin
            for (int k = 0; k < 64; k++) begin
                if (p != 0) begin
                    term = udiv64(p, 64'(2 * k + 1));
                    sum  = k[0] ? sum - term : sum + term;
                    p    = (2 * i < 64) ? p >> (2 * i) : 64'd0;
                end
            end
        end
        return word_t'(sum);
    endfunction

    // radians per half-unit of 1e-7 degree, Q90
    function automatic word_t rad_per_unit();
        logic [63:0] pi;
        logic [63:0] q;
        logic [63:0] r;
        pi = 4 * quarter_pi();
        q  = udiv64(pi, HALF_UNITS);
        r  = pi - q * HALF_UNITS;
        return word_t'((q << 30) + udiv64(r << 30, HALF_UNITS));
    endfunction

    // inverse CORDIC gain by Newton iteration on 1/sqrt(prod)
    function automatic word_t gain_value(input int n);
        word_t prod;
        word_t y;
        word_t t;
        prod = ONE;
        for (int i = 0; i < n; i++) begin
            if (2 * i < 63) prod = prod + (prod >>> (2 * i));
        end
        y = 6 * word_t'(udiv64(64'(ONE), 64'd10));
        for (int k = 0; k < 12; k++) begin
            t = mul_shift_c(prod, mul_shift_c(y, y, FRAC), FRAC);
            y = mul_shift_c(y, 3 * ONE - t, FRAC + 1);
        end
        return y;
    endfunction

endpackage

FILE: design/haversine_distance.sv
// haversine_distance: fully pipelined great-circle distance, one word per cycle
// while the output is not stalled. The two CORDIC chains and the 64-step
// square-root chain hold most of its pipeline registers.
// A stalled output word freezes the whole pipeline; nothing is dropped.
// Synchronous active-low reset clears all valid bits; data registers keep junk.
module haversine_distance #(
    parameter int CORDIC_STAGES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_lat_a,
    input  logic signed [31:0] s_lon_a,
    input  logic signed [30:0] s_lat_b,
    input  logic signed [31:0] s_lon_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_distance_cm
);
    import hvd_pkg::*;

    localparam word_t RPU  = rad_per_unit();
    localparam word_t GAIN = gain_value(CORDIC_STAGES);
    localparam logic signed [35:0] TURN_U    = 36'sd7200000000;
    localparam logic signed [35:0] HALF_U    = 36'sd3600000000;
    localparam logic signed [35:0] QUARTER_U = 36'sd1800000000;

    // fold an angle (half-units of 1e-7 degree) into [-90, 90] degree
    function automatic logic [32:0] fold(input logic signed [33:0] a);
        logic signed [35:0] r;
        logic               f;
        r = 36'(a);
        f = 1'b0;
        if (r > HALF_U) r = r - TURN_U;
        if (r < -HALF_U) r = r + TURN_U;
        if (r > QUARTER_U) begin
            r = r - HALF_U;
            f = 1'b1;
        end else if (r < -QUARTER_U) begin
            r = r + HALF_U;
            f = 1'b1;
        end
        return {f, r[31:0]};
    endfunction

    logic en;

    logic signed [33:0] ang_reg [4];
    logic               ang_valid_reg;
    logic signed [31:0] red_r_reg [4];
    logic [3:0]         red_flip_reg;
    logic               red_valid_reg;
    logic [3:0]         flip_d_reg [MUL_LAT];
    word_t              rad_z [4];
    word_t              cos_w [4];
    word_t              sin_w [4];
    logic               rot_valid;
    word_t              sdsq, c12, slsq, t2;
    logic               m1_valid, m2_valid;
    word_t              sdsq_d_reg [MUL_LAT];
    word_t              h_sum_reg;
    logic               h_sum_valid_reg;
    logic [63:0]        h_u_reg [2];
    logic               h_u_valid_reg;
    logic [63:0]        sq_root_reg [SQRT_STEPS][2];
    logic [63:0]        sq_rem_reg [SQRT_STEPS][2];
    logic [63:0]        sq_u_reg [SQRT_STEPS][2];
    logic               sq_valid_reg [SQRT_STEPS];
    word_t              vec_x, vec_y, vec_ang;
    logic               vec_valid;
    word_t              dist_raw;
    logic               dist_valid;
    word_t              h_clamp;
    logic [30:0]        dist_clamp;
    logic [30:0]        m_distance_cm_reg;
    logic               m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && aresetn;

    // input stage: the four angles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_valid_reg <= 1'b0;
            red_valid_reg <= 1'b0;
        end else if (en) begin
            ang_valid_reg <= s_valid;
            red_valid_reg <= ang_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg[0] <= 34'(s_lat_a) <<< 1;
            ang_reg[1] <= 34'(s_lat_b) <<< 1;
            ang_reg[2] <= 34'(s_lat_b) - 34'(s_lat_a);
            ang_reg[3] <= 34'(s_lon_b) - 34'(s_lon_a);
            for (int u = 0; u < 4; u++) begin
                {red_flip_reg[u], red_r_reg[u]} <= fold(ang_reg[u]);
            end
            flip_d_reg[0] <= red_flip_reg;
            for (int i = 1; i < MUL_LAT; i++) flip_d_reg[i] <= flip_d_reg[i-1];
        end
    end

    // lanes: 0 lat_a, 1 lat_b, 2 half dlat, 3 half dlon
    for (genvar u = 0; u < 4; u++) begin : g_trig
        logic rv, cv;
        hvd_mul #(.SHIFT(30)) u_rad (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(red_valid_reg), .a(64'(red_r_reg[u])), .b(RPU),
            .out_valid(rv), .p(rad_z[u])
        );
        hvd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(rv), .x_in(GAIN), .y_in('0), .z_in(rad_z[u]),
            .neg_in(flip_d_reg[MUL_LAT-1][u]),
            .out_valid(cv), .x_out(cos_w[u]), .y_out(sin_w[u]), .z_out()
        );
        if (u == 0) begin : g_v
            assign rot_valid = cv;
        end
    end

    hvd_mul #(.SHIFT(FRAC)) u_sdsq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rot_valid),
        .a(sin_w[2]), .b(sin_w[2]), .out_valid(m1_valid), .p(sdsq)
    );
    hvd_mul #(.SHIFT(FRAC)) u_c12 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rot_valid),
        .a(cos_w[0]), .b(cos_w[1]), .out_valid(), .p(c12)
    );
    hvd_mul #(.SHIFT(FRAC)) u_slsq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rot_valid),
        .a(sin_w[3]), .b(sin_w[3]), .out_valid(), .p(slsq)
    );
    hvd_mul #(.SHIFT(FRAC)) u_t2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(m1_valid),
        .a(c12), .b(slsq), .out_valid(m2_valid), .p(t2)
    );

    assign h_clamp = (h_sum_reg < 0) ? '0 : ((h_sum_reg > ONE) ? ONE : h_sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_sum_valid_reg <= 1'b0;
            h_u_valid_reg   <= 1'b0;
        end else if (en) begin
            h_sum_valid_reg <= m2_valid;
            h_u_valid_reg   <= h_sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sdsq_d_reg[0] <= sdsq;
            for (int i = 1; i < MUL_LAT; i++) sdsq_d_reg[i] <= sdsq_d_reg[i-1];
            h_sum_reg  <= sdsq_d_reg[MUL_LAT-1] + t2;
            h_u_reg[0] <= 64'(h_clamp);
            h_u_reg[1] <= 64'(ONE - h_clamp);
        end
    end

    // digit-by-digit floor roots of h and 1-h, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sq
        localparam int K = SQRT_STEPS - 1 - j;
        logic v_p;

        if (j == 0) begin : g_first
            assign v_p = h_u_valid_reg;
        end else begin : g_next
            assign v_p = sq_valid_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[j] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[j] <= v_p;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [63:0]  root_p, rem_p, u_p, rem_s, trial;
            logic [127:0] rad_v;

            if (j == 0) begin : g_first
                assign root_p = '0;
                assign rem_p  = '0;
                assign u_p    = h_u_reg[l];
            end else begin : g_next
                assign root_p = sq_root_reg[j-1][l];
                assign rem_p  = sq_rem_reg[j-1][l];
                assign u_p    = sq_u_reg[j-1][l];
            end

            assign rad_v = {4'd0, u_p, 60'd0};
            assign rem_s = {rem_p[61:0], rad_v[2*K+1:2*K]};
            assign trial = {root_p[61:0], 2'b01};

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (rem_s >= trial) begin
                        sq_rem_reg[j][l]  <= rem_s - trial;
                        sq_root_reg[j][l] <= {root_p[62:0], 1'b1};
                    end else begin
                        sq_rem_reg[j][l]  <= rem_s;
                        sq_root_reg[j][l] <= {root_p[62:0], 1'b0};
                    end
                    sq_u_reg[j][l] <= u_p;
                end
            end
        end
    end

    assign vec_y = (sq_root_reg[SQRT_STEPS-1][0] > 64'(ONE)) ? ONE
                 : word_t'(sq_root_reg[SQRT_STEPS-1][0]);
    assign vec_x = word_t'(sq_root_reg[SQRT_STEPS-1][1]);

    hvd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_vec (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_valid_reg[SQRT_STEPS-1]), .x_in(vec_x), .y_in(vec_y), .z_in('0),
        .neg_in(1'b0),
        .out_valid(vec_valid), .x_out(), .y_out(), .z_out(vec_ang)
    );

    hvd_mul #(.SHIFT(FRAC)) u_dist (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vec_valid),
        .a(vec_ang), .b(TWO_R_CM), .out_valid(dist_valid), .p(dist_raw)
    );

    assign dist_clamp = (dist_raw < 0) ? '0
                      : ((dist_raw > MAX_CM) ? MAX_CM[30:0] : dist_raw[30:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dist_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_distance_cm_reg <= dist_clamp;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_distance_cm = m_distance_cm_reg;

`ifndef SYNTHESIS
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_distance_cm <= MAX_CM[30:0])
        else $error("distance word above half circumference");

    a_h_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        h_u_valid_reg |-> (h_u_reg[0] <= 64'(ONE)) && (h_u_reg[1] <= 64'(ONE)))
        else $error("haversine term outside [0, 1]");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_valid_reg[SQRT_STEPS-1] |-> sq_root_reg[SQRT_STEPS-1][0] <= 64'(ONE))
        else $error("root of haversine term above one");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(h_sum_reg) && $stable(h_sum_valid_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule

FILE: design/hvd_mul.sv
// hvd_mul: four-stage pipelined signed 64x64 multiply, shift right and round
// (ties away from zero). Depends on hvd_pkg.
module hvd_mul #(
    parameter int SHIFT = 60
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hvd_pkg::word_t a,
    input  hvd_pkg::word_t b,
    output logic          out_valid,
    output hvd_pkg::word_t p
);
    import hvd_pkg::*;

    localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

    logic [63:0]  ma_reg, mb_reg;
    logic         neg1_reg, v1_reg;
    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic         neg2_reg, v2_reg;
    logic [62:0]  q_reg;
    logic         neg3_reg, v3_reg;
    word_t        p_reg;
    logic         v4_reg;
    logic [127:0] sum_next;

    assign sum_next = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
                    + {64'd0, ll_reg} + RND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= a[63] ? 64'(-a) : 64'(a);
            mb_reg   <= b[63] ? 64'(-b) : 64'(b);
            neg1_reg <= a[63] ^ b[63];
            ll_reg   <= {32'd0, ma_reg[31:0]}  * {32'd0, mb_reg[31:0]};
            lh_reg   <= {32'd0, ma_reg[31:0]}  * {32'd0, mb_reg[63:32]};
            hl_reg   <= {32'd0, ma_reg[63:32]} * {32'd0, mb_reg[31:0]};
            hh_reg   <= {32'd0, ma_reg[63:32]} * {32'd0, mb_reg[63:32]};
            neg2_reg <= neg1_reg;
            q_reg    <= sum_next[SHIFT+62:SHIFT];
            neg3_reg <= neg2_reg;
            p_reg    <= neg3_reg ? -word_t'({1'b0, q_reg}) : word_t'({1'b0, q_reg});
        end
    end

    assign out_valid = v4_reg;
    assign p         = p_reg;

endmodule

FILE: design/hvd_cordic.sv
// hvd_cordic: one-iteration-per-stage CORDIC, rotation or vectoring mode,
// with optional negation of x and y at the output. Depends on hvd_pkg.
module hvd_cordic #(
    parameter int STAGES = 32,
    parameter bit VECTOR = 1'b0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hvd_pkg::word_t x_in,
    input  hvd_pkg::word_t y_in,
    input  hvd_pkg::word_t z_in,
    input  logic          neg_in,
    output logic          out_valid,
    output hvd_pkg::word_t x_out,
    output hvd_pkg::word_t y_out,
    output hvd_pkg::word_t z_out
);
    import hvd_pkg::*;

    word_t x_reg [STAGES];
    word_t y_reg [STAGES];
    word_t z_reg [STAGES];
    logic  neg_reg [STAGES];
    logic  v_reg [STAGES];
    word_t xo_reg, yo_reg, zo_reg;
    logic  vo_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam word_t ATN = atn_entry(i);
        word_t x_p, y_p, z_p, dx, dy;
        logic  n_p, v_p, go;

        if (i == 0) begin : g_first
            assign x_p = x_in;
            assign y_p = y_in;
            assign z_p = z_in;
            assign n_p = neg_in;
            assign v_p = in_valid;
        end else begin : g_next
            assign x_p = x_reg[i-1];
            assign y_p = y_reg[i-1];
            assign z_p = z_reg[i-1];
            assign n_p = neg_reg[i-1];
            assign v_p = v_reg[i-1];
        end

        assign dx = y_p >>> i;
        assign dy = x_p >>> i;
        // rotation drives z to zero, vectoring drives y to zero
        assign go = VECTOR ? (y_p > 0) : (z_p >= 0);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (go ^ VECTOR) begin
                    x_reg[i] <= x_p - dx;
                    y_reg[i] <= y_p + dy;
                end else begin
                    x_reg[i] <= x_p + dx;
                    y_reg[i] <= y_p - dy;
                end
                z_reg[i]   <= (go ^ VECTOR) ? z_p - ATN : z_p + ATN;
                neg_reg[i] <= n_p;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xo_reg <= neg_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
            yo_reg <= neg_reg[STAGES-1] ? -y_reg[STAGES-1] : y_reg[STAGES-1];
            zo_reg <= z_reg[STAGES-1];
        end
    end

    assign out_valid = vo_reg;
    assign x_out     = xo_reg;
    assign y_out     = yo_reg;
    assign z_out     = zo_reg;

endmodule

FILE: dv/testbench.sv
// Testbench for haversine_distance: drives point pairs through the valid/ready
// ports and checks every distance word against a bit-exact fixed-point predictor.
// Depends only on the RTL (top module haversine_distance).
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STAGES     = 32;
    localparam int  FBITS      = 60;
    localparam longint UNIT    = 64'sd1 << FBITS;
    localparam longint TURN    = 64'sd7200000000;
    localparam longint HALF    = 64'sd3600000000;
    localparam longint QUARTER = 64'sd1800000000;
    localparam longint TWO_R   = 64'sd1274200000;
    localparam longint CM_MAX  = 64'sd2001508680;
    localparam int  PIPE_LAT   = 2 * STAGES + 87;
    localparam int  RANDOM_WORDS = 1750;
    localparam longint LIMIT   = 400000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [30:0] s_lat_a = '0;
    logic signed [31:0] s_lon_a = '0;
    logic signed [30:0] s_lat_b = '0;
    logic signed [31:0] s_lon_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [30:0]        m_distance_cm;

    haversine_distance #(.CORDIC_STAGES(STAGES)) DUT (.*);

    always #5 aclk = ~aclk;

    typedef struct {
        logic [30:0] cm;      // predicted distance
        longint      near_cm; // hand value, checked to within 2 cm; -1 if none
    } dist_t;

    dist_t  dist_q[$];
    longint atan_tab[STAGES];
    longint rad_scale;
    longint cordic_gain;
    int     mismatches = 0;
    int     words_in = 0;
    int     words_out = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_active = 1'b0;
    longint cycles = 0;
    event   hold_off_go;

    // ---------------- predictor ----------------
    function automatic longint rmul(longint a, longint b, int s);
        bit          neg;
        bit [63:0]   ua;
        bit [63:0]   ub;
        bit [127:0]  p;
        bit [63:0]   q;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        p   = {64'd0, ua} * {64'd0, ub};
        p   = p + (128'd1 << (s - 1));
        q   = 64'(p >> s) & 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned arctan_recip(longint unsigned n);
        longint unsigned p, nn, acc, term;
        p   = longint'(UNIT) / n;
        nn  = n * n;
        acc = 0;
        for (int k = 0; k < 64 && p != 0; k++) begin
            term = p / (2 * k + 1);
            acc  = k[0] ? acc - term : acc + term;
            p    = p / nn;
        end
        return acc;
    endfunction

    task automatic build_angle_tables();
        longint unsigned qpi, pi_v, p, acc, term, q, r;
        longint prod, y, t;
        qpi = 4 * arctan_recip(5) - arctan_recip(239);
        pi_v = 4 * qpi;
        atan_tab[0] = qpi;
        for (int i = 1; i < STAGES; i++) begin
            p = longint'(UNIT) >> i;
            acc = 0;
            for (int k = 0; k < 64 && p != 0; k++) begin
                term = p / (2 * k + 1);
                acc  = k[0] ? acc - term : acc + term;
                p    = (2 * i < 64) ? p >> (2 * i) : 0;
            end
            atan_tab[i] = acc;
        end
        q = pi_v / longint'(HALF);
        r = pi_v % longint'(HALF);
        rad_scale = (q << 30) + ((r << 30) / longint'(HALF));
        prod = UNIT;
        for (int i = 0; i < STAGES; i++)
            if (2 * i < 63) prod = prod + (prod >>> (2 * i));
        y = 6 * (UNIT / 10);
        for (int k = 0; k < 12; k++) begin
            t = rmul(prod, rmul(y, y, FBITS), FBITS);
            y = rmul(y, 3 * UNIT - t, FBITS + 1);
        end
        cordic_gain = y;
    endtask

    // angle in units of 0.5e-7 degree
    function automatic void rotate_angle(input longint a, output longint c,
            output longint s);
        longint r, z, x, y, dx, dy;
        bit flip;
        r = a % TURN;
        flip = 1'b0;
        if (r > HALF) r -= TURN;
        if (r < -HALF) r += TURN;
        if (r > QUARTER) begin
            r -= HALF;
            flip = 1'b1;
        end else if (r < -QUARTER) begin
            r += HALF;
            flip = 1'b1;
        end
        z = rmul(r, rad_scale, 30);
        x = cordic_gain;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint root_q60(longint v);
        bit [127:0] val, rem, trial;
        bit [63:0]  root;
        val  = {64'd0, 64'(v)} << FBITS;
        rem  = 0;
        root = 0;
        for (int k = 63; k >= 0; k--) begin
            rem   = (rem << 2) | ((val >> (2 * k)) & 128'd3);
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
        end
        return longint'(root);
    endfunction

    function automatic logic [30:0] great_circle_cm(logic signed [30:0] la,
            logic signed [31:0] oa, logic signed [30:0] lb, logic signed [31:0] ob);
        longint c1, s1, c2, s2, cd, sd, cl, sl, h, sq, tq, x, y, z, dx, dy, d;
        rotate_angle(2 * longint'(la), c1, s1);
        rotate_angle(2 * longint'(lb), c2, s2);
        rotate_angle(longint'(lb) - longint'(la), cd, sd);
        rotate_angle(longint'(ob) - longint'(oa), cl, sl);
        h = rmul(sd, sd, FBITS) +
            rmul(rmul(c1, c2, FBITS), rmul(sl, sl, FBITS), FBITS);
        if (h < 0) h = 0;
        if (h > UNIT) h = UNIT;
        sq = root_q60(h);
        if (sq > UNIT) sq = UNIT;
        tq = root_q60(UNIT - h);
        // vectoring CORDIC: atan2(sq, tq)
        x = tq; y = sq; z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        d = rmul(z, TWO_R, FBITS);
        if (d < 0) d = 0;
        if (d > CM_MAX) d = CM_MAX;
        return d[30:0];
    endfunction

    // ---------------- sender ----------------
    task automatic send_pair(logic signed [30:0] la, logic signed [31:0] oa,
            logic signed [30:0] lb, logic signed [31:0] ob, longint near_cm);
        dist_t e;
        e.cm = great_circle_cm(la, oa, lb, ob);
        e.near_cm = near_cm;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_lat_a <= la;
        s_lon_a <= oa;
        s_lat_b <= lb;
        s_lon_b <= ob;
        do @(posedge aclk); while (!s_ready);
        dist_q = {dist_q, e};
        words_in++;
        @(negedge aclk);
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        return 32'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
    endfunction

    task automatic send_random();
        logic signed [30:0] la, lb;
        logic signed [31:0] oa, ob;
        int kind;
        kind = $urandom_range(99);
        la = rand_lat();
        oa = rand_lon();
        if (kind < 10) begin
            // raw bit patterns, out-of-range angles wrap
            la = 31'($urandom); oa = $urandom; lb = 31'($urandom); ob = $urandom;
        end else if (kind < 25) begin
            // nearby point, tiny haversine term
            lb = la + 31'($signed($urandom_range(0, 2000)) - 1000);
            ob = oa + 32'($signed($urandom_range(0, 2000)) - 1000);
        end else if (kind < 40) begin
            // near antipode, term close to one
            lb = -la + 31'($signed($urandom_range(0, 2000)) - 1000);
            ob = oa + 32'sd1800000000 + 32'($signed($urandom_range(0, 2000)) - 1000);
        end else begin
            lb = rand_lat();
            ob = rand_lon();
        end
        send_pair(la, oa, lb, ob, -1);
    endtask

    // ---------------- receiver and checker ----------------
    always @(negedge aclk)
        m_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);

    initial forever begin
        @(hold_off_go);
        hold_active = 1'b1;
        repeat (600) @(negedge aclk);
        hold_active = 1'b0;
    end

    always @(posedge aclk) begin
        dist_t e;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (dist_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected distance word %0d", m_distance_cm);
            end else begin
                e = dist_q.pop_front();
                if (m_distance_cm !== e.cm || (e.near_cm >= 0 &&
                        (longint'(m_distance_cm) > e.near_cm + 2 ||
                         longint'(m_distance_cm) < e.near_cm - 2))) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("distance_cm mismatch: expected %0d (hand %0d), got %0d",
                                 e.cm, e.near_cm, m_distance_cm);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("haversine_distance verification failed");
            $finish;
        end
    end

    // ---------------- directed table ----------------
    typedef struct {
        logic signed [30:0] la;
        logic signed [31:0] oa;
        logic signed [30:0] lb;
        logic signed [31:0] ob;
        longint             near_cm;
    } pair_row_t;

    localparam int ROWS = 18;
    pair_row_t pair_rows[ROWS] = '{
        '{31'sd0, 32'sd0, 31'sd0, 32'sd0, 0},
        '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, 2001508680},
        '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, 2001508680},
        '{31'sd0, 32'sd0, 31'sd0, 32'sd900000000, 1000754340},
        '{31'sd0, 32'sd0, 31'sd900000000, 32'sd0, 1000754340},
        '{31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000, 0},
        '{-31'sd900000000, -32'sd1800000000, 31'sd900000000, 32'sd1800000000, -1},
        '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, -1},
        '{31'sd123456789, 32'sd987654321, 31'sd123456790, 32'sd987654321, -1},
        '{31'sd450000000, 32'sd100000000, -31'sd450000000, -32'sd1700000000, -1},
        '{31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000, -1},
        '{31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF, -1},
        '{-31'sd1, -32'sd1, 31'sd0, 32'sd0, -1},
        '{31'sh7FFFFFFF, 32'shFFFFFFFF, 31'sh7FFFFFFF, 32'shFFFFFFFF, -1},
        '{31'sd1000000000, 32'sd0, 31'sd0, 32'sd0, -1},
        '{31'sh2AAAAAAA, 32'sh55555555, 31'sh55555555, 32'shAAAAAAAA, -1},
        '{31'sd899999999, 32'sd1, -31'sd899999999, 32'sd1800000001, -1},
        '{31'sd515000000, -32'sd1000000, 31'sd407000000, -32'sd740000000, -1}
    };

    initial begin
        build_angle_tables();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (pair_rows[i])
            send_pair(pair_rows[i].la, pair_rows[i].oa, pair_rows[i].lb,
                      pair_rows[i].ob, pair_rows[i].near_cm);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            case (n * 5 / RANDOM_WORDS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // long output hold-off while words keep coming: pipeline fills, input stalls
            if (n == RANDOM_WORDS * 4 / 5) -> hold_off_go;
            send_random();
        end
        s_valid <= 1'b0;
        recv_stall_pct = 0;

        while (dist_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 50) @(posedge aclk);

        $display("%0d point pairs sent, %0d distances checked over four idle/stall mixes",
                 words_in, words_out);
        $display("plus a 600-cycle output hold-off; %0d mismatches", mismatches);
        if (mismatches == 0 && dist_q.size() == 0)
            $display("haversine_distance verification clean");
        else
            $display("haversine_distance verification failed");
        $finish;
    end
endmodule

FILE: sim.f
design/hvd_pkg.sv
design/hvd_mul.sv
design/hvd_cordic.sv
design/haversine_distance.sv
dv/testbench.sv
